[rtl/lts_pkg.sv]
// Shared types and constants for the LRU tag store with writeback marks.
// Used by the cell and the top level; depends on nothing.
`default_nettype none

package lts_pkg;

	// default store size and key width
	localparam int CAPACITY_DEF = 32;
	localparam int KEY_BITS_DEF = 16;

	// request kinds
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	// flags that ride the scan chain from cell to cell
	typedef struct packed {
		logic hit;        // a valid entry with the request key was seen
		logic free;       // an empty slot was seen
		logic lru;        // the least recent entry was seen
		logic lru_dirty;  // dirty mark of that entry
	} lts_scan_t;

	// update command broadcast to every cell at commit
	typedef struct packed {
		logic en;      // apply an update this cycle
		logic is_hit;  // refresh an existing entry
		logic is_set;  // request was a set
		logic dirty;   // dirty mark to store
	} lts_upd_t;

endpackage : lts_pkg

`default_nettype wire

[rtl/lru_tag_store_with_writeback.sv]
// Top level of the LRU tag store: request/result handshakes, scan sequencing, row of cells.
// Depends on lts_pkg and lts_cell.
`default_nettype none

// Fully associative tag store of CAPACITY entries in true LRU order, one entry per cell.
// A request is taken when s_axis_tready is high, which is whenever no other request is in
// progress. The request key is broadcast to all cells and a scan chain carries the first
// hit, the first free slot and the least recent entry from cell to cell, one cell per cycle;
// a final commit step applies the age, dirty and insert update to every cell on a hit or
// a set and loads the result register.
// The result waits in its own register, so the next request may be accepted and scanned
// while it is held; commit of that next request waits until the result has been taken.
// Each request passes through the scan along the chain, the commit and an idle state in
// which the next request is taken, so a new request waits until the last one has committed.
// No clearing pass is needed after reset.

module lru_tag_store_with_writeback import lts_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	localparam int SLOT_W   = $clog2(CAPACITY),
	localparam int IN_W     = ((KEY_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W    = ((3 + SLOT_W + KEY_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request stream
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,   // key, dirty_in, zero fill
	input  wire logic             s_axis_tuser,   // cmd
	// result stream
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata    // hit, slot, evicted, evicted_key,
	                                              // writeback, zero fill
);

	localparam logic [SLOT_W-1:0] LAST_CNT = SLOT_W'(CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic                dirty_q;
	logic                m_valid_q;
	logic [OUT_W-1:0]    m_data_q;

	logic                accept;
	logic                commit;
	logic                out_take;

	// scan chain, one hop per cell; index 0 is the empty start
	lts_scan_t           ch_flags [0:CAPACITY];
	logic [SLOT_W-1:0]   ch_hit_slot [0:CAPACITY];
	logic [SLOT_W-1:0]   ch_hit_age [0:CAPACITY];
	logic [SLOT_W-1:0]   ch_free_slot [0:CAPACITY];
	logic [SLOT_W-1:0]   ch_lru_slot [0:CAPACITY];
	logic [KEY_BITS-1:0] ch_lru_key [0:CAPACITY];

	lts_upd_t            upd;
	logic [SLOT_W-1:0]   upd_slot;
	logic [SLOT_W-1:0]   upd_age;

	lts_scan_t           tail;
	logic                full;
	logic                r_hit;
	logic [SLOT_W-1:0]   r_slot;
	logic                r_ev;
	logic [KEY_BITS-1:0] r_evk;
	logic                r_wb;
	logic [OUT_W-1:0]    out_d;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_take      = m_valid_q && m_axis_tready;
	assign commit        = (state_q == ST_COMMIT) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// sequence: accept, scan the chain, commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the request for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_axis_tuser;
			key_q   <= s_axis_tdata[KEY_BITS-1:0];
			dirty_q <= s_axis_tdata[KEY_BITS];
		end
	end

	// empty start of the chain
	assign ch_flags[0]     = '0;
	assign ch_hit_slot[0]  = '0;
	assign ch_hit_age[0]   = '0;
	assign ch_free_slot[0] = '0;
	assign ch_lru_slot[0]  = '0;
	assign ch_lru_key[0]   = '0;

	// row of entry cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lts_cell #(
			.CAPACITY (CAPACITY),
			.KEY_BITS (KEY_BITS),
			.INDEX    (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.req_key       (key_q),
			.in_flags      (ch_flags[i]),
			.in_hit_slot   (ch_hit_slot[i]),
			.in_hit_age    (ch_hit_age[i]),
			.in_free_slot  (ch_free_slot[i]),
			.in_lru_slot   (ch_lru_slot[i]),
			.in_lru_key    (ch_lru_key[i]),
			.out_flags     (ch_flags[i+1]),
			.out_hit_slot  (ch_hit_slot[i+1]),
			.out_hit_age   (ch_hit_age[i+1]),
			.out_free_slot (ch_free_slot[i+1]),
			.out_lru_slot  (ch_lru_slot[i+1]),
			.out_lru_key   (ch_lru_key[i+1]),
			.upd           (upd),
			.upd_slot      (upd_slot),
			.upd_age       (upd_age),
			.upd_key       (key_q)
		);
	end

	// decide the result and the update from the chain tail
	always_comb begin
		tail   = ch_flags[CAPACITY];
		full   = !tail.free;
		r_hit  = tail.hit;
		r_slot = '0;
		r_ev   = 1'b0;
		r_evk  = '0;
		r_wb   = 1'b0;
		upd    = '0;
		upd_age = ch_hit_age[CAPACITY];
		if (tail.hit) begin
			r_slot     = ch_hit_slot[CAPACITY];
			upd.is_hit = 1'b1;
		end else if (cmd_q == CMD_SET) begin
			if (full) begin
				r_ev   = 1'b1;
				r_slot = tail.lru ? ch_lru_slot[CAPACITY] : '0;
				r_evk  = tail.lru ? ch_lru_key[CAPACITY] : '0;
				r_wb   = tail.lru && tail.lru_dirty;
			end else begin
				r_slot = ch_free_slot[CAPACITY];
			end
		end
		upd.en     = commit && (tail.hit || (cmd_q == CMD_SET));
		upd.is_set = (cmd_q == CMD_SET);
		upd.dirty  = dirty_q;
		upd_slot   = r_slot;
	end

	// pack the result fields, lowest first
	always_comb begin
		out_d                               = '0;
		out_d[0]                            = r_hit;
		out_d[SLOT_W:1]                     = r_slot;
		out_d[SLOT_W+1]                     = r_ev;
		out_d[SLOT_W+2 +: KEY_BITS]         = r_evk;
		out_d[SLOT_W+2+KEY_BITS]            = r_wb;
	end

	// result register: load at commit, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (out_take) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= out_d;
		end
	end

endmodule : lru_tag_store_with_writeback

`default_nettype wire

[rtl/lts_cell.sv]
// One entry of the tag store: key, valid, dirty and age, plus one stage of the scan chain.
// Depends on lts_pkg for the chain flags and the update command.
`default_nettype none

module lts_cell import lts_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int INDEX    = 0,
	localparam int SLOT_W  = $clog2(CAPACITY)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request key, held for the whole scan
	input  wire logic [KEY_BITS-1:0] req_key,
	// scan chain from the previous cell
	input  wire lts_scan_t           in_flags,
	input  wire logic [SLOT_W-1:0]   in_hit_slot,
	input  wire logic [SLOT_W-1:0]   in_hit_age,
	input  wire logic [SLOT_W-1:0]   in_free_slot,
	input  wire logic [SLOT_W-1:0]   in_lru_slot,
	input  wire logic [KEY_BITS-1:0] in_lru_key,
	// scan chain to the next cell
	output lts_scan_t                out_flags,
	output logic [SLOT_W-1:0]        out_hit_slot,
	output logic [SLOT_W-1:0]        out_hit_age,
	output logic [SLOT_W-1:0]        out_free_slot,
	output logic [SLOT_W-1:0]        out_lru_slot,
	output logic [KEY_BITS-1:0]      out_lru_key,
	// update broadcast
	input  wire lts_upd_t            upd,
	input  wire logic [SLOT_W-1:0]   upd_slot,
	input  wire logic [SLOT_W-1:0]   upd_age,
	input  wire logic [KEY_BITS-1:0] upd_key
);

	localparam logic [SLOT_W-1:0] MY_IDX  = SLOT_W'(INDEX);
	localparam logic [SLOT_W-1:0] OLDEST  = SLOT_W'(CAPACITY - 1);

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic                dirty_q;
	logic [SLOT_W-1:0]   age_q;

	logic      match;
	logic      lru_here;
	logic      self;
	lts_scan_t flags_d;

	assign match    = valid_q && (key_q == req_key);
	assign lru_here = valid_q && (age_q == OLDEST);
	assign self     = (upd_slot == MY_IDX);

	// merge this entry into the chain: first hit, first free, last oldest
	always_comb begin
		flags_d.hit       = in_flags.hit | match;
		flags_d.free      = in_flags.free | ~valid_q;
		flags_d.lru       = in_flags.lru | lru_here;
		flags_d.lru_dirty = lru_here ? dirty_q : in_flags.lru_dirty;
	end

	// chain flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_flags <= '0;
		end else begin
			out_flags <= flags_d;
		end
	end

	// chain payload
	always_ff @(posedge clk) begin
		out_hit_slot  <= in_flags.hit ? in_hit_slot : MY_IDX;
		out_hit_age   <= in_flags.hit ? in_hit_age : age_q;
		out_free_slot <= in_flags.free ? in_free_slot : MY_IDX;
		out_lru_slot  <= lru_here ? MY_IDX : in_lru_slot;
		out_lru_key   <= lru_here ? key_q : in_lru_key;
	end

	// entry control state: valid, dirty, age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			age_q   <= '0;
		end else if (upd.en) begin
			if (upd.is_hit) begin
				// refresh: younger entries age by one
				if (self) begin
					age_q <= '0;
					if (upd.is_set) begin
						dirty_q <= upd.dirty;
					end
				end else if (valid_q && (age_q < upd_age)) begin
					age_q <= age_q + 1'b1;
				end
			end else if (self) begin
				// insert into the chosen slot
				valid_q <= 1'b1;
				dirty_q <= upd.dirty;
				age_q   <= '0;
			end else if (valid_q) begin
				age_q <= age_q + 1'b1;
			end
		end
	end

	// entry key: written on insert only
	always_ff @(posedge clk) begin
		if (upd.en && !upd.is_hit && self) begin
			key_q <= upd_key;
		end
	end

endmodule : lts_cell

`default_nettype wire

[rtl/lts_check.sv]
// Port checker for the LRU tag store, bound to the top level.
// Sees the top level's ports only; no package dependency.
`default_nettype none

module lts_check #(
	parameter int CAPACITY  = 32,
	parameter int KEY_BITS  = 16,
	localparam int SLOT_W   = $clog2(CAPACITY),
	localparam int IN_W     = ((KEY_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W    = ((3 + SLOT_W + KEY_BITS + 7) / 8) * 8,
	localparam int EV_POS   = SLOT_W + 1,
	localparam int EVK_POS  = SLOT_W + 2,
	localparam int WB_POS   = SLOT_W + 2 + KEY_BITS
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic [IN_W-1:0]  s_axis_tdata,
	input wire logic             s_axis_tuser,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	// a waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("request changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// once a request is accepted, the block is busy and not ready
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken during a scan");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[EV_POS])
		else $error("eviction reported on a hit");

	// without eviction, key and writeback read zero
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[EV_POS] |->
			!m_axis_tdata[WB_POS] && (m_axis_tdata[EVK_POS +: KEY_BITS] == '0))
		else $error("evicted key or writeback set without eviction");

endmodule : lts_check

bind lru_tag_store_with_writeback lts_check #(
	.CAPACITY (CAPACITY),
	.KEY_BITS (KEY_BITS)
) u_lts_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
